// ----- rtl/core/rtip_pkg.sv -----
// Package for the radix integer text parser: character codes, bases,
// register indexes, counter width and the digit unit's result type.
// No dependencies.
package rtip_pkg;

    localparam int MAX_LEN = 255;
    localparam int CNT_W   = $clog2(MAX_LEN + 1);

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2b;
    localparam logic [7:0] CH_MINUS = 8'h2d;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UB    = 8'h42;
    localparam logic [7:0] CH_UX    = 8'h58;
    localparam logic [7:0] CH_UZ    = 8'h5a;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LB    = 8'h62;
    localparam logic [7:0] CH_LX    = 8'h78;
    localparam logic [7:0] CH_LZ    = 8'h7a;

    localparam logic [5:0] BASE_BIN = 6'd2;
    localparam logic [5:0] BASE_OCT = 6'd8;
    localparam logic [5:0] BASE_DEC = 6'd10;
    localparam logic [5:0] BASE_HEX = 6'd16;

    localparam logic [7:0] REG_RADIX  = 8'd0;
    localparam logic [7:0] REG_SIGNED = 8'd1;

    typedef struct packed {
        logic        hit;
        logic [63:0] acc;
    } digit_res_t;

endpackage

// ----- rtl/core/radix_integer_text_parser.sv -----
// Radix integer text parser, top level: input register, parse state machine
// and result register. Depends on rtip_pkg and rtip_digit.
// The result of a terminating character passes from the input register to the
// result register. Throughput: one character per cycle, set by the single
// multiply-add by the base between the input and result registers; a result
// waiting on m_ready holds the input.
// Reset (aresetn low, synchronous): parse done and waiting for a first
// character, radix 10, unsigned mode, both channels empty.
module radix_integer_text_parser
    import rtip_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_ch,
    input  logic        s_first,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [63:0] m_value,
    output logic [7:0]  m_end_offset,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_index,
    input  logic [7:0]  cfg_data
);

    typedef enum logic [2:0] {
        PH_DONE,
        PH_BLANK1,
        PH_BLANK2,
        PH_ZAUTO,
        PH_ZHEX,
        PH_DIGITS
    } phase_t;

    phase_t             phase_reg, phase_next;
    logic [63:0]        acc_reg, acc_next;
    logic [5:0]         base_reg, base_next;
    logic               neg_reg, neg_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [5:0]         radix_reg;
    logic               signed_reg;

    logic               in_valid_reg;
    logic [7:0]         ch_reg;
    logic               first_reg;

    logic               m_valid_reg;
    logic [63:0]        value_reg;
    logic [7:0]         offset_reg;

    logic               proc;
    logic               emit;
    logic [63:0]        emit_value;
    logic [CNT_W+7:0]   cnt_ext;

    phase_t             ph0;
    logic [63:0]        acc0;
    logic [5:0]         base0;
    logic [5:0]         base_eff;
    logic [CNT_W-1:0]   cnt0;
    logic [CNT_W-1:0]   cnt_adv;
    logic               blank;
    logic               take_digit;
    digit_res_t         dres;

    assign proc      = in_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || proc;
    assign cfg_ready = 1'b1;
    assign m_valid      = m_valid_reg;
    assign m_value      = value_reg;
    assign m_end_offset = offset_reg;

    assign blank = (ch_reg == CH_SP) || (ch_reg == CH_TAB);

    // restart on first
    always_comb begin
        ph0   = phase_reg;
        acc0  = acc_reg;
        base0 = base_reg;
        cnt0  = cnt_reg;
        if (first_reg) begin
            acc0  = 64'd0;
            cnt0  = '0;
            base0 = (radix_reg == 6'd0) ? BASE_DEC : radix_reg;
            ph0   = signed_reg ? PH_BLANK1 : PH_BLANK2;
        end
        cnt_adv = (cnt0 < CNT_W'(MAX_LEN)) ? cnt0 + CNT_W'(1) : cnt0;
        case (ph0)
            PH_BLANK1, PH_BLANK2: base_eff = (radix_reg == 6'd0) ? BASE_DEC : radix_reg;
            PH_ZAUTO:             base_eff = (ch_reg == CH_NUL) ? BASE_DEC : BASE_OCT;
            default:              base_eff = base0;
        endcase
    end

    rtip_digit u_digit (
        .ch   (ch_reg),
        .base (base_eff),
        .acc  (acc0),
        .res  (dres)
    );

    always_comb begin
        phase_next = ph0;
        acc_next   = acc0;
        base_next  = base0;
        neg_next   = first_reg ? 1'b0 : neg_reg;
        cnt_next   = cnt0;
        take_digit = 1'b0;
        case (ph0)
            PH_BLANK1, PH_BLANK2: begin
                if (blank) begin
                    cnt_next = cnt_adv;
                end else if (ph0 == PH_BLANK1 && (ch_reg == CH_MINUS || ch_reg == CH_PLUS)) begin
                    neg_next   = (ch_reg == CH_MINUS);
                    phase_next = PH_BLANK2;
                    cnt_next   = cnt_adv;
                end else if (radix_reg == 6'd0 && ch_reg == CH_0) begin
                    phase_next = PH_ZAUTO;
                    cnt_next   = cnt_adv;
                end else if (radix_reg == BASE_HEX && ch_reg == CH_0) begin
                    base_next  = radix_reg;
                    phase_next = PH_ZHEX;
                    cnt_next   = cnt_adv;
                end else begin
                    take_digit = 1'b1;
                end
            end
            PH_ZAUTO: begin
                if (ch_reg == CH_LX || ch_reg == CH_UX) begin
                    base_next  = BASE_HEX;
                    phase_next = PH_DIGITS;
                    cnt_next   = cnt_adv;
                end else if (ch_reg == CH_LB || ch_reg == CH_UB) begin
                    base_next  = BASE_BIN;
                    phase_next = PH_DIGITS;
                    cnt_next   = cnt_adv;
                end else begin
                    take_digit = 1'b1;
                end
            end
            PH_ZHEX: begin
                if (ch_reg == CH_LX || ch_reg == CH_UX) begin
                    phase_next = PH_DIGITS;
                    cnt_next   = cnt_adv;
                end else begin
                    take_digit = 1'b1;
                end
            end
            PH_DIGITS: take_digit = 1'b1;
            default:   take_digit = 1'b0;
        endcase
        emit = 1'b0;
        if (take_digit) begin
            base_next = base_eff;
            if (dres.hit) begin
                acc_next   = dres.acc;
                phase_next = PH_DIGITS;
                cnt_next   = cnt_adv;
            end else begin
                emit       = 1'b1;
                phase_next = PH_DONE;
            end
        end
        emit_value = neg_next ? (64'd0 - acc0) : acc0;
        cnt_ext    = {8'd0, cnt0};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_DONE;
            acc_reg      <= 64'd0;
            base_reg     <= BASE_DEC;
            neg_reg      <= 1'b0;
            cnt_reg      <= '0;
            radix_reg    <= BASE_DEC;
            signed_reg   <= 1'b0;
            in_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == REG_RADIX) begin
                    radix_reg <= cfg_data[5:0];
                end else if (cfg_index == REG_SIGNED) begin
                    signed_reg <= cfg_data[0];
                end
            end
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
                ch_reg       <= s_ch;
                first_reg    <= s_first;
            end else if (proc) begin
                in_valid_reg <= 1'b0;
            end
            if (proc) begin
                phase_reg <= phase_next;
                acc_reg   <= acc_next;
                base_reg  <= base_next;
                neg_reg   <= neg_next;
                cnt_reg   <= cnt_next;
            end
            if (proc && emit) begin
                m_valid_reg <= 1'b1;
                value_reg   <= emit_value;
                offset_reg  <= cnt_ext[7:0];
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_W'(MAX_LEN))
        else $error("consumed count beyond saturation limit");

    assert property (@(posedge aclk) disable iff (!aresetn)
        proc && emit |=> phase_reg == PH_DONE && m_valid)
        else $error("terminating word did not close the parse");

    assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg != PH_DONE |-> base_reg != 6'd0)
        else $error("active base is zero during a parse");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && !$changed(m_value) ||
        !m_valid)
        else $error("stalled result word lost");

endmodule

// ----- rtl/core/rtip_digit.sv -----
// Digit unit: maps a character to its letter-digit value, checks it against
// the base and forms acc * base + digit modulo 2^64.
// Depends on rtip_pkg.
module rtip_digit
    import rtip_pkg::*;
(
    input  logic [7:0]  ch,
    input  logic [5:0]  base,
    input  logic [63:0] acc,
    output digit_res_t  res
);

    logic [7:0]  diff;
    logic [5:0]  dval;
    logic        is_digit;
    logic [69:0] prod;

    always_comb begin
        diff     = 8'd0;
        is_digit = 1'b0;
        if (ch >= CH_0 && ch <= CH_9) begin
            diff     = ch - CH_0;
            is_digit = 1'b1;
        end else if (ch >= CH_LA && ch <= CH_LZ) begin
            diff     = ch - CH_LA + 8'd10;
            is_digit = 1'b1;
        end else if (ch >= CH_UA && ch <= CH_UZ) begin
            diff     = ch - CH_UA + 8'd10;
            is_digit = 1'b1;
        end
        dval = diff[5:0];
    end

    assign prod    = {6'd0, acc} * {64'd0, base};
    assign res.hit = is_digit && (dval < base);
    assign res.acc = prod[63:0] + {58'd0, dval};

endmodule
